>>> src/tmph_pkg.sv
// Shared types and constants for the trimmed-mean pH reader.
// No dependencies; imported by every module of the block.
`default_nettype none

package tmph_pkg;

  // input item codes
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE    = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [15:0]        INTERVAL_RST = 16'd50;
  localparam logic [12:0]        NEUTRAL_RST  = 13'd2500;
  localparam logic signed [10:0] SLOPE_RST    = -11'sd180;

  // accumulator widths and reset values
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned TAKEN_W = 4;
  localparam logic [ADC_W-1:0] ADC_MAX = 12'd4095;

  // scaling constants: full scale 2 * 3.3 V over 4095 codes, pH 7 at the middle
  localparam logic [12:0] MV_SCALE = 13'd6600;
  localparam logic [6:0]  CENTI    = 7'd100;
  localparam logic signed [21:0] PH_MID = 22'sd700;
  localparam logic signed [21:0] PH_TOP = 22'sd1400;

  // voltage scaling by reciprocal multiplication
  localparam int unsigned RECIP_W  = 33;
  localparam int unsigned MV_SHIFT = 32;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;

  // slope divider geometry
  localparam int unsigned DIV_W     = 20;
  localparam int unsigned DIVR_W    = 11;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned PMUL_W    = 20;

  typedef struct packed {
    logic        command;
    logic [11:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic [14:0] trimmed_sum;
    logic [12:0] module_mv;
    logic [10:0] ph_centi;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic clear_run;
    logic tick;
    logic load_prod;
    logic div_start;
    logic load_mv;
    logic load_diff;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_take;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> src/tmph_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tmph_pkg for operand widths.
`default_nettype none

module tmph_div import tmph_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [DIVR_W-1:0] divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     work_r, work_nxt;
  logic [DIVR_W-1:0]    rem_r, rem_nxt;
  logic [DIVR_W-1:0]    den_r, den_nxt;
  logic [DIVR_W:0]      rem_sh;
  logic [DIVR_W:0]      rem_sub;
  logic                 ge;

  // one shift and trial subtract
  always_comb begin
    rem_sh   = {rem_r, work_r[DIV_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
      work_nxt = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      work_nxt = {work_r[DIV_W-2:0], ge};
      rem_nxt  = ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

`default_nettype wire

>>> src/tmph_datapath.sv
// Datapath: configuration registers, sample accumulators, scaling and output word.
// Depends on tmph_pkg and instantiates tmph_div.
`default_nettype none

module tmph_datapath import tmph_pkg::*; #(
  parameter int unsigned SAMPLES = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [ADC_W-1:0]     sample,
  input  wire cmd_t                 cmd,
  output status_t                   sts,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output out_word_t                 out_word
);

  // mv = floor(trimmed * 6600 / den), exact for every 16-bit trimmed sum
  localparam logic [63:0] MV_DEN = 64'((SAMPLES - 2) * 4095);
  localparam logic [RECIP_W-1:0] MV_RECIP =
    RECIP_W'(((64'(MV_SCALE) << MV_SHIFT) + MV_DEN - 64'd1) / MV_DEN);
  localparam logic [TAKEN_W-1:0] TAKE_END = TAKEN_W'(SAMPLES);

  logic [15:0]        interval_r;
  logic [12:0]        neutral_r;
  logic signed [10:0] slope_r;

  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [TAKEN_W-1:0] taken_r, taken_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [ADC_W-1:0]   min_r, min_nxt;
  logic [ADC_W-1:0]   max_r, max_nxt;

  logic [15:0]        elapsed_inc;
  logic               hit;
  logic [SUM_W-1:0]   trimmed;

  logic [SUM_W-1:0]   trim_r;
  logic [PROD_W-1:0]  prod_r;
  logic [12:0]        mv_r;
  logic [PMUL_W-1:0]  pmul_r;
  logic               neg_r;

  logic [DIV_W-1:0]   div_dividend;
  logic [DIVR_W-1:0]  div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;

  logic [10:0]        slope_mag;
  logic [13:0]        diff;
  logic [12:0]        diff_mag;
  logic [21:0]        q_ext;
  logic signed [21:0] ph_raw;
  logic [10:0]        ph;

  logic               out_valid_r;
  out_word_t          out_word_r;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      neutral_r  <= NEUTRAL_RST;
      slope_r    <= SLOPE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_NEUTRAL:  neutral_r  <= cfg_data[12:0];
        CFG_SLOPE:    slope_r    <= signed'(cfg_data[10:0]);
        default:      ;
      endcase
    end
  end

  // sample timing: saturating tick counter against the interval
  always_comb begin
    elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
    hit         = !(elapsed_inc < interval_r);
  end

  assign sts.last_take = hit && ((taken_r + 1'b1) == TAKE_END);

  // accumulator update
  always_comb begin
    elapsed_nxt = elapsed_r;
    taken_nxt   = taken_r;
    sum_nxt     = sum_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    if (cmd.clear_run) begin
      elapsed_nxt = '0;
      taken_nxt   = '0;
      sum_nxt     = '0;
      min_nxt     = ADC_MAX;
      max_nxt     = '0;
    end else if (cmd.tick) begin
      if (hit) begin
        elapsed_nxt = '0;
        taken_nxt   = taken_r + 1'b1;
        sum_nxt     = sum_r + SUM_W'(sample);
        if (sample < min_r) min_nxt = sample;
        if (sample > max_r) max_nxt = sample;
      end else begin
        elapsed_nxt = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      taken_r   <= '0;
      sum_r     <= '0;
      min_r     <= ADC_MAX;
      max_r     <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      taken_r   <= taken_nxt;
      sum_r     <= sum_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
    end
  end

  // trimmed sum; min and max are both part of the sum so this never goes negative
  assign trimmed = sum_r - SUM_W'(min_r) - SUM_W'(max_r);

  // signed operand magnitudes
  always_comb begin
    slope_mag = slope_r[10] ? (~slope_r + 11'd1) : slope_r;
    diff      = {1'b0, neutral_r} - {1'b0, mv_r};
    diff_mag  = diff[13] ? 13'(~diff + 14'd1) : diff[12:0];
  end

  // scaling registers
  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      trim_r <= trimmed;
      prod_r <= PROD_W'(trimmed) * PROD_W'(MV_RECIP);
    end
    if (cmd.load_mv) begin
      mv_r <= prod_r[MV_SHIFT +: 13];
    end
    if (cmd.load_diff) begin
      pmul_r <= {7'b0, diff_mag} * {13'b0, CENTI};
      neg_r  <= diff[13] ^ slope_r[10];
    end
  end

  // divider for the slope term
  assign div_dividend = pmul_r;
  assign div_divisor  = slope_mag;

  tmph_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign sts.div_done = div_done;

  // pH offset from neutral, then clamp to the scale; a zero slope gives pH 7
  always_comb begin
    q_ext  = {2'b0, div_quot[PMUL_W-1:0]};
    ph_raw = neg_r ? (PH_MID - signed'(q_ext)) : (PH_MID + signed'(q_ext));
    if (slope_r == '0) begin
      ph = 11'(PH_MID);
    end else if (ph_raw[21]) begin
      ph = '0;
    end else if (ph_raw > PH_TOP) begin
      ph = 11'(PH_TOP);
    end else begin
      ph = ph_raw[10:0];
    end
  end

  // result register, refilled once the waiting word is taken
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r.trimmed_sum <= trim_r[14:0];
      out_word_r.module_mv   <= mv_r;
      out_word_r.ph_centi    <= ph;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

>>> src/tmph_ctrl.sv
// Controller: measurement state and the sequence of the final computation.
// Depends on tmph_pkg for the command and status structs.
`default_nettype none

module tmph_ctrl import tmph_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    command,
  input  wire status_t sts,
  output logic         in_stall,
  output cmd_t         cmd
);

  typedef enum logic [6:0] {
    ST_RUN     = 7'b000_0001,
    ST_MUL     = 7'b000_0010,
    ST_MV      = 7'b000_0100,
    ST_DIFF    = 7'b000_1000,
    ST_PHSTART = 7'b001_0000,
    ST_PHDIV   = 7'b010_0000,
    ST_OUT     = 7'b100_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    cmd       = '0;
    accept    = in_valid && (state_r == ST_RUN);
    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (command == CMD_REQUEST) begin
            if (!busy_r) begin
              busy_nxt      = 1'b1;
              cmd.clear_run = 1'b1;
            end
          end else if (busy_r) begin
            cmd.tick = 1'b1;
            if (sts.last_take) state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.load_prod = 1'b1;
        state_nxt     = ST_MV;
      end
      ST_MV: begin
        cmd.load_mv = 1'b1;
        state_nxt   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.load_diff = 1'b1;
        state_nxt     = ST_PHSTART;
      end
      ST_PHSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_PHDIV;
      end
      ST_PHDIV: begin
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.clear_run = 1'b1;
          busy_nxt      = 1'b0;
          state_nxt     = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign in_stall = (state_r != ST_RUN);

endmodule

`default_nettype wire

>>> src/trimmed_mean_ph_reader.sv
// Top level of the trimmed-mean pH reader: controller plus datapath.
// Depends on tmph_pkg, tmph_ctrl, tmph_datapath and tmph_div.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_word   (command, adc_sample)
//   out      out_valid / out_stall out_word  (trimmed_sum, module_mv, ph_centi)
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Request and tick words are taken one per cycle while in_stall is low.
// The tick that brings the last sample holds in_stall high through the product,
// voltage, difference and divider start states, the 20-bit bit-serial division
// by the slope, and the output state.
// The result is written into the output register, and in_stall stays high
// beyond that only while an earlier result still waits under out_stall.
// rst_n is synchronous; no clearing pass is needed after it. cfg_ready is always high.
`default_nettype none

module trimmed_mean_ph_reader import tmph_pkg::*; #(
  parameter int unsigned SAMPLES = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  tmph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .command  (in_word.command),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tmph_datapath #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (in_word.adc_sample),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // a new result only appears at the end of a stalled computation
  a_result_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a computation phase");

  // pH stays within its clamp
  a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.ph_centi <= 11'd1400))
    else $error("ph_centi out of range");

  // module voltage never exceeds full scale
  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.module_mv <= 13'd6600))
    else $error("module_mv out of range");
`endif

endmodule

`default_nettype wire
